// ===== hw/rtl/froll_pkg.sv =====
// shared types, constants and the cordic arctangent table for the face roll angle block
// no dependencies; used by froll_cordic_lane, froll_merge and the top level
package froll_pkg;

    localparam int COORD_BITS    = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int ITERS         = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int NUM_COORDS = 8;
    localparam int S_DATA_W   = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = 24;
    localparam int M_USER_W   = 2;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int XY_W   = DIFF_W + 19;
    localparam int Z_W    = 26;

    localparam int W_W     = 16;
    localparam int PROD_W  = Z_W + W_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int RND_SH  = 22;
    localparam int ROLL_W  = SUM_W - RND_SH;
    localparam int V_W     = ROLL_W + 1;
    localparam int GAIN_W  = 16;
    localparam int P_W     = V_W + GAIN_W;
    localparam int RES_W   = P_W + 1 - 8;

    localparam int LANE_LAT  = ITERS + 1;
    localparam int MERGE_LAT = 5;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam logic signed [Z_W-1:0]   DEG90   = Z_W'(90 * 65536);
    localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(8388607);
    localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(8388608);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EYE_WEIGHT   = 3'd0,
        CFG_MOUTH_WEIGHT = 3'd1,
        CFG_DEADZONE     = 3'd2,
        CFG_INVERT_SIGN  = 3'd3,
        CFG_ROLL_GAIN    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [W_W-1:0]           eye_weight;
        logic [W_W-1:0]           mouth_weight;
        logic [15:0]              deadzone;
        logic                     invert_sign;
        logic signed [GAIN_W-1:0] roll_gain;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] eye_lx;
        logic [COORD_BITS-1:0] eye_ly;
        logic [COORD_BITS-1:0] eye_rx;
        logic [COORD_BITS-1:0] eye_ry;
        logic [COORD_BITS-1:0] mouth_lx;
        logic [COORD_BITS-1:0] mouth_ly;
        logic [COORD_BITS-1:0] mouth_rx;
        logic [COORD_BITS-1:0] mouth_ry;
    } keypts_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] r;
        unique case (idx)
            0:  r = Z_W'(2949120);
            1:  r = Z_W'(1740967);
            2:  r = Z_W'(919879);
            3:  r = Z_W'(466945);
            4:  r = Z_W'(234379);
            5:  r = Z_W'(117304);
            6:  r = Z_W'(58666);
            7:  r = Z_W'(29335);
            8:  r = Z_W'(14668);
            9:  r = Z_W'(7334);
            10: r = Z_W'(3667);
            11: r = Z_W'(1833);
            12: r = Z_W'(917);
            13: r = Z_W'(458);
            14: r = Z_W'(229);
            15: r = Z_W'(115);
            16: r = Z_W'(57);
            17: r = Z_W'(29);
            18: r = Z_W'(14);
            19: r = Z_W'(7);
            20: r = Z_W'(4);
            21: r = Z_W'(2);
            22: r = Z_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/froll_cordic_lane.sv =====
// one pipelined cordic vectoring lane: keypoint difference, quadrant fold, one stage per iteration
// depends on froll_pkg
module froll_cordic_lane (
    input  logic                                     aclk,
    input  logic                                     en,
    input  logic [froll_pkg::COORD_BITS-1:0]         a_x,
    input  logic [froll_pkg::COORD_BITS-1:0]         a_y,
    input  logic [froll_pkg::COORD_BITS-1:0]         b_x,
    input  logic [froll_pkg::COORD_BITS-1:0]         b_y,
    output logic signed [froll_pkg::Z_W-1:0]         angle
);

    logic signed [froll_pkg::DIFF_W-1:0] dx;
    logic signed [froll_pkg::DIFF_W-1:0] dy;
    logic signed [froll_pkg::DIFF_W-1:0] rx;
    logic signed [froll_pkg::DIFF_W-1:0] ry;
    logic signed [froll_pkg::Z_W-1:0]    rz;
    logic signed [froll_pkg::XY_W-1:0]   rx_ext;
    logic signed [froll_pkg::XY_W-1:0]   ry_ext;

    logic signed [froll_pkg::XY_W-1:0] x_reg    [0:froll_pkg::ITERS];
    logic signed [froll_pkg::XY_W-1:0] y_reg    [0:froll_pkg::ITERS];
    logic signed [froll_pkg::Z_W-1:0]  z_reg    [0:froll_pkg::ITERS];
    logic                              zero_reg [0:froll_pkg::ITERS];

    always_comb begin
        dx = $signed({1'b0, b_x}) - $signed({1'b0, a_x});
        dy = $signed({1'b0, b_y}) - $signed({1'b0, a_y});
        rx = dx;
        ry = dy;
        rz = '0;
        if (dx < 0) begin
            if (dy >= 0) begin
                rx = dy;
                ry = -dx;
                rz = froll_pkg::DEG90;
            end else begin
                rx = -dy;
                ry = dx;
                rz = -froll_pkg::DEG90;
            end
        end
        rx_ext = froll_pkg::XY_W'(rx) <<< 16;
        ry_ext = froll_pkg::XY_W'(ry) <<< 16;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= rx_ext;
            y_reg[0]    <= ry_ext;
            z_reg[0]    <= rz;
            zero_reg[0] <= (dx == '0) && (dy == '0);
        end
    end

    for (genvar i = 0; i < froll_pkg::ITERS; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + froll_pkg::atan_q16(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - froll_pkg::atan_q16(i);
                end
            end
        end
    end

    assign angle = zero_reg[froll_pkg::ITERS] ? '0 : z_reg[froll_pkg::ITERS];

endmodule

// ===== hw/rtl/froll_merge.sv =====
// merge of the eye and mouth lanes: weighting, rounding, deadzone, sign, gain and saturation
// depends on froll_pkg
module froll_merge (
    input  logic                                 aclk,
    input  logic                                 en,
    input  froll_pkg::cfg_t                      cfg,
    input  logic signed [froll_pkg::Z_W-1:0]     eye_angle,
    input  logic signed [froll_pkg::Z_W-1:0]     mouth_angle,
    output logic signed [froll_pkg::M_DATA_W-1:0] roll_angle,
    output logic                                 in_deadzone,
    output logic                                 saturated
);

    logic signed [froll_pkg::PROD_W-1:0]   pe_reg;
    logic signed [froll_pkg::PROD_W-1:0]   pm_reg;
    logic signed [froll_pkg::SUM_W-1:0]    sum_rnd;
    logic signed [froll_pkg::ROLL_W-1:0]   roll_reg;
    logic signed [froll_pkg::V_W-1:0]      roll_ext;
    logic signed [froll_pkg::V_W-1:0]      mag;
    logic signed [froll_pkg::V_W-1:0]      v_reg;
    logic                                  dz3_reg;
    logic signed [froll_pkg::P_W-1:0]      p_reg;
    logic                                  dz4_reg;
    logic signed [froll_pkg::P_W:0]        p_rnd;
    logic signed [froll_pkg::RES_W-1:0]    res;
    logic signed [froll_pkg::M_DATA_W-1:0] roll_angle_reg;
    logic                                  in_deadzone_reg;
    logic                                  saturated_reg;

    always_comb begin
        sum_rnd  = froll_pkg::SUM_W'(pe_reg) + froll_pkg::SUM_W'(pm_reg)
                 + froll_pkg::SUM_W'(2 ** (froll_pkg::RND_SH - 1));
        roll_ext = froll_pkg::V_W'(roll_reg);
        mag      = (roll_ext < 0) ? -roll_ext : roll_ext;
        p_rnd    = (froll_pkg::P_W + 1)'(p_reg) + (froll_pkg::P_W + 1)'(128);
        res      = froll_pkg::RES_W'(p_rnd >>> 8);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // weighted angles
            pe_reg <= froll_pkg::PROD_W'($signed({1'b0, cfg.eye_weight}) * eye_angle);
            pm_reg <= froll_pkg::PROD_W'($signed({1'b0, cfg.mouth_weight}) * mouth_angle);
            // sum rounded to 1/256 degree
            roll_reg <= froll_pkg::ROLL_W'(sum_rnd >>> froll_pkg::RND_SH);
            // deadzone test and sign
            dz3_reg <= (mag <= $signed({1'b0, froll_pkg::V_W'(cfg.deadzone)}));
            v_reg   <= cfg.invert_sign ? -roll_ext : roll_ext;
            // gain
            p_reg   <= froll_pkg::P_W'(v_reg * $signed(cfg.roll_gain));
            dz4_reg <= dz3_reg;
            // round and clip
            in_deadzone_reg <= dz4_reg;
            if (dz4_reg) begin
                roll_angle_reg <= '0;
                saturated_reg  <= 1'b0;
            end else if (res > froll_pkg::OUT_MAX) begin
                roll_angle_reg <= froll_pkg::M_DATA_W'(froll_pkg::OUT_MAX);
                saturated_reg  <= 1'b1;
            end else if (res < froll_pkg::OUT_MIN) begin
                roll_angle_reg <= froll_pkg::M_DATA_W'(froll_pkg::OUT_MIN);
                saturated_reg  <= 1'b1;
            end else begin
                roll_angle_reg <= froll_pkg::M_DATA_W'(res);
                saturated_reg  <= 1'b0;
            end
        end
    end

    assign roll_angle  = roll_angle_reg;
    assign in_deadzone = in_deadzone_reg;
    assign saturated   = saturated_reg;

endmodule

// ===== hw/rtl/face_roll_angle_from_keypoints.sv =====
// face roll angle from eye and mouth keypoints: input skid stage, two cordic lanes, merge
// the pipeline runs through a fold register, one stage per cordic iteration, then the merge registers
// throughput is one face per cycle; a full output stalls the pipeline and the skid stage takes one more
// reset (aresetn low, synchronous) clears valid bits and loads the register defaults
// depends on froll_pkg, froll_cordic_lane and froll_merge
module face_roll_angle_from_keypoints (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // eye_lx, eye_ly, eye_rx, eye_ry,
    // mouth_lx, mouth_ly, mouth_rx, mouth_ry
    input  logic [froll_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // roll_angle
    output logic [froll_pkg::M_DATA_W-1:0]      m_tdata,
    // in_deadzone, saturated
    output logic [froll_pkg::M_USER_W-1:0]      m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [froll_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [froll_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CB = froll_pkg::COORD_BITS;

    froll_pkg::cfg_t    cfg_reg;
    froll_pkg::keypts_t in_pts;
    froll_pkg::keypts_t skid_reg;
    froll_pkg::keypts_t src_pts;
    logic               skid_vld_reg;
    logic               skid_vld_next;
    logic [froll_pkg::TOTAL_LAT-1:0] vld_reg;
    logic [froll_pkg::TOTAL_LAT-1:0] vld_next;
    logic               s_fire;
    logic               adv;
    logic signed [froll_pkg::Z_W-1:0]      eye_angle;
    logic signed [froll_pkg::Z_W-1:0]      mouth_angle;
    logic signed [froll_pkg::M_DATA_W-1:0] roll_angle;
    logic               in_deadzone;
    logic               saturated;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.eye_weight   <= 16'd8192;
            cfg_reg.mouth_weight <= 16'd8192;
            cfg_reg.deadzone     <= 16'd1280;
            cfg_reg.invert_sign  <= 1'b0;
            cfg_reg.roll_gain    <= 16'sd256;
        end else if (cfg_valid) begin
            unique case (froll_pkg::cfg_idx_t'(cfg_index))
                froll_pkg::CFG_EYE_WEIGHT:   cfg_reg.eye_weight   <= cfg_data;
                froll_pkg::CFG_MOUTH_WEIGHT: cfg_reg.mouth_weight <= cfg_data;
                froll_pkg::CFG_DEADZONE:     cfg_reg.deadzone     <= cfg_data;
                froll_pkg::CFG_INVERT_SIGN:  cfg_reg.invert_sign  <= cfg_data[0];
                froll_pkg::CFG_ROLL_GAIN:    cfg_reg.roll_gain    <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_pts.eye_lx   = s_tdata[0*CB +: CB];
        in_pts.eye_ly   = s_tdata[1*CB +: CB];
        in_pts.eye_rx   = s_tdata[2*CB +: CB];
        in_pts.eye_ry   = s_tdata[3*CB +: CB];
        in_pts.mouth_lx = s_tdata[4*CB +: CB];
        in_pts.mouth_ly = s_tdata[5*CB +: CB];
        in_pts.mouth_rx = s_tdata[6*CB +: CB];
        in_pts.mouth_ry = s_tdata[7*CB +: CB];
    end

    // whole pipeline moves unless the output holds an untaken transfer
    assign adv      = !vld_reg[froll_pkg::TOTAL_LAT-1] || m_tready;
    assign s_tready = !skid_vld_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign src_pts  = skid_vld_reg ? skid_reg : in_pts;

    always_comb begin
        skid_vld_next = skid_vld_reg ? !adv : (s_fire && !adv);
        vld_next      = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[froll_pkg::TOTAL_LAT-2:0], skid_vld_reg || s_fire};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_vld_reg <= 1'b0;
            vld_reg      <= '0;
        end else begin
            skid_vld_reg <= skid_vld_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && !adv) begin
            skid_reg <= in_pts;
        end
    end

    froll_cordic_lane u_eye_lane (
        .aclk  (aclk),
        .en    (adv),
        .a_x   (src_pts.eye_lx),
        .a_y   (src_pts.eye_ly),
        .b_x   (src_pts.eye_rx),
        .b_y   (src_pts.eye_ry),
        .angle (eye_angle)
    );

    froll_cordic_lane u_mouth_lane (
        .aclk  (aclk),
        .en    (adv),
        .a_x   (src_pts.mouth_lx),
        .a_y   (src_pts.mouth_ly),
        .b_x   (src_pts.mouth_rx),
        .b_y   (src_pts.mouth_ry),
        .angle (mouth_angle)
    );

    froll_merge u_merge (
        .aclk        (aclk),
        .en          (adv),
        .cfg         (cfg_reg),
        .eye_angle   (eye_angle),
        .mouth_angle (mouth_angle),
        .roll_angle  (roll_angle),
        .in_deadzone (in_deadzone),
        .saturated   (saturated)
    );

    assign m_tvalid = vld_reg[froll_pkg::TOTAL_LAT-1];
    assign m_tdata  = roll_angle;
    assign m_tuser  = {saturated, in_deadzone};

endmodule
